// File: src/srs_pkg.sv
// Shared codes, types and helpers of the selective-repeat sender.
`timescale 1ns / 1ps
package srs_pkg;

  typedef logic [1:0] kind_t;
  typedef logic [2:0] status_t;
  typedef logic [1:0] timer_t;

  localparam kind_t KIND_NEW   = 2'd0;
  localparam kind_t KIND_ACK   = 2'd1;
  localparam kind_t KIND_TIMER = 2'd2;
  localparam kind_t KIND_NONE  = 2'd3;

  localparam status_t ST_SENT      = 3'd0;
  localparam status_t ST_FULL      = 3'd1;
  localparam status_t ST_CORRUPT   = 3'd2;
  localparam status_t ST_OUT_WIN   = 3'd3;
  localparam status_t ST_DUPLICATE = 3'd4;
  localparam status_t ST_NEW_ACK   = 3'd5;
  localparam status_t ST_RESENT    = 3'd6;

  localparam timer_t TMR_NONE    = 2'd0;
  localparam timer_t TMR_START   = 2'd1;
  localparam timer_t TMR_STOP    = 2'd2;
  localparam timer_t TMR_RESTART = 2'd3;

  localparam logic       REG_WINDOW_LIMIT = 1'b0;
  localparam logic [3:0] WINDOW_RESET     = 4'd6;
  localparam logic [31:0] ACK_FIELD_NONE  = 32'hFFFF_FFFF;

  localparam int PAYLOAD_W = 160;
  localparam int GROUPS    = 5;
  localparam int IN_DATA_W  = 256;
  localparam int OUT_DATA_W = 200;

  // sum of the four unsigned bytes of one 32-bit word
  function automatic logic [9:0] group_sum(input logic [31:0] w);
    logic [8:0] a;
    logic [8:0] b;
    a = {1'b0, w[7:0]} + {1'b0, w[15:8]};
    b = {1'b0, w[23:16]} + {1'b0, w[31:24]};
    return {1'b0, a} + {1'b0, b};
  endfunction

endpackage

// File: src/srs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
`timescale 1ns / 1ps
module srs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/selective_repeat_sender_unit.sv
// Top level of the selective-repeat ARQ sender: event sequencer around payload and ack RAMs.
//
//  channel  | role   | payload
//  ---------+--------+--------------------------------------------------------
//  s_axis   | input  | tuser: kind; tdata: payload, ACK seq/ack/check fields
//  m_axis   | output | tuser: status; tdata: packet, timer_action
//  apb      | config | window_limit at byte address 0
//
// One event at a time. New message: byte sum, then send or report full. Timer expiry:
// payload RAM read, then byte sum, then resend. ACK: byte sum, then checksum and
// window check, then an ack-flag RAM read finds a duplicate; else the flag is set and the
// base slides to the first unacknowledged entry, one ack-flag RAM read per step.
// Reset clears control state; the RAMs need no clearing pass.
// A result waiting in the output register stalls only the sequencer's final step.
`timescale 1ns / 1ps
module selective_repeat_sender_unit #(
  parameter int SEQ_SPACE = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [63:0] payload_lo, [127:64] payload_mid, [159:128] payload_hi,
  // [191:160] ack_seq_field, [223:192] ack_number, [255:224] ack_check_field
  input  logic [255:0] s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [0] send_valid, [4:1] send_seq, [36:5] send_check, [100:37] send_payload_lo,
  // [164:101] send_payload_mid, [196:165] send_payload_hi, [198:197] timer_action
  output logic [199:0] m_axis_tdata,
  // [2:0] status
  output logic [2:0]   m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int SW = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RD     = 4'd1;
  localparam logic [3:0] S_SUM    = 4'd2;
  localparam logic [3:0] S_NEW    = 4'd3;
  localparam logic [3:0] S_ACK    = 4'd4;
  localparam logic [3:0] S_ACK_RD = 4'd5;
  localparam logic [3:0] S_WALK   = 4'd6;
  localparam logic [3:0] S_WCHK   = 4'd7;
  localparam logic [3:0] S_ADONE  = 4'd8;
  localparam logic [3:0] S_RS     = 4'd9;

  function automatic logic [SW-1:0] mod_diff(input logic [SW-1:0] a, input logic [SW-1:0] b);
    if (a >= b) begin
      return a - b;
    end
    return SW'({1'b0, a} + (SW+1)'(SEQ_SPACE) - {1'b0, b});
  endfunction

  function automatic logic [SW-1:0] mod_inc(input logic [SW-1:0] a);
    if (a == SW'(SEQ_SPACE - 1)) begin
      return '0;
    end
    return a + SW'(1);
  endfunction

  logic [3:0]   state, state_next;
  logic [3:0]   window_limit;
  logic [SW-1:0] window_base, window_base_next;
  logic [SW-1:0] next_seq, next_seq_next;

  srs_pkg::kind_t kind;
  logic [srs_pkg::PAYLOAD_W-1:0] pay;
  logic [31:0]  ack_seq, ack_num, ack_chk;
  logic [9:0]   grp [srs_pkg::GROUPS];
  logic [12:0]  psum;

  logic         pay_we;
  logic [srs_pkg::PAYLOAD_W-1:0] pay_rdata;
  logic         flag_we, flag_wdata, flag_rdata;
  logic [SW-1:0] flag_waddr, flag_raddr;

  logic         out_free, res_load;
  logic [srs_pkg::OUT_DATA_W-1:0] res_data;
  srs_pkg::status_t res_status;

  logic [SW-1:0] outstanding, lim_eff, ack_idx;
  logic [31:0]  ack_calc;
  logic         cfg_wr;

  srs_ram #(.WIDTH(srs_pkg::PAYLOAD_W), .DEPTH(SEQ_SPACE)) u_payload_ram (
    .clk   (clk),
    .we    (pay_we),
    .waddr (next_seq),
    .wdata (pay),
    .raddr (window_base),
    .rdata (pay_rdata)
  );

  srs_ram #(.WIDTH(1), .DEPTH(SEQ_SPACE)) u_acked_ram (
    .clk   (clk),
    .we    (flag_we),
    .waddr (flag_waddr),
    .wdata (flag_wdata),
    .raddr (flag_raddr),
    .rdata (flag_rdata)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign pready        = 1'b1;
  assign cfg_wr        = psel && penable && pwrite && pready;
  assign prdata        = (paddr[2] == srs_pkg::REG_WINDOW_LIMIT) ? {28'd0, window_limit} : 32'd0;

  assign psum = 13'(grp[0]) + 13'(grp[1]) + 13'(grp[2]) + 13'(grp[3]) + 13'(grp[4]);
  assign outstanding = mod_diff(next_seq, window_base);
  assign ack_idx  = ack_num[SW-1:0];
  assign ack_calc = ack_seq + ack_num + 32'(psum);

  always_comb begin
    if (int'(window_limit) > SEQ_SPACE - 1) begin
      lim_eff = SW'(SEQ_SPACE - 1);
    end else begin
      lim_eff = SW'(window_limit);
    end
  end

  always_comb begin
    state_next       = state;
    window_base_next = window_base;
    next_seq_next    = next_seq;
    pay_we           = 1'b0;
    flag_we          = 1'b0;
    flag_waddr       = next_seq;
    flag_wdata       = 1'b0;
    flag_raddr       = (state == S_ACK) ? ack_idx : window_base;
    res_load         = 1'b0;
    res_data         = '0;
    res_status       = srs_pkg::ST_SENT;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          case (s_axis_tuser)
            srs_pkg::KIND_NEW, srs_pkg::KIND_ACK: state_next = S_SUM;
            srs_pkg::KIND_TIMER:                  state_next = S_RD;
            default:                              state_next = S_IDLE;
          endcase
        end
      end
      S_RD: state_next = S_SUM;
      S_SUM: begin
        case (kind)
          srs_pkg::KIND_NEW: state_next = S_NEW;
          srs_pkg::KIND_ACK: state_next = S_ACK;
          default:           state_next = S_RS;
        endcase
      end
      S_NEW: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
          if (outstanding >= lim_eff) begin
            res_status = srs_pkg::ST_FULL;
          end else begin
            pay_we        = 1'b1;
            flag_we       = 1'b1;
            next_seq_next = mod_inc(next_seq);
            res_status    = srs_pkg::ST_SENT;
            res_data      = {1'b0,
                             (window_base == next_seq) ? srs_pkg::TMR_START : srs_pkg::TMR_NONE,
                             pay[159:128], pay[127:64], pay[63:0],
                             32'(next_seq) + srs_pkg::ACK_FIELD_NONE + 32'(psum),
                             4'(next_seq), 1'b1};
          end
        end
      end
      S_ACK: begin
        if (ack_calc != ack_chk) begin
          if (out_free) begin
            res_load   = 1'b1;
            res_status = srs_pkg::ST_CORRUPT;
            state_next = S_IDLE;
          end
        end else if (ack_num >= 32'(SEQ_SPACE) ||
                     mod_diff(ack_idx, window_base) >= outstanding) begin
          if (out_free) begin
            res_load   = 1'b1;
            res_status = srs_pkg::ST_OUT_WIN;
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_ACK_RD;
        end
      end
      S_ACK_RD: begin
        if (flag_rdata) begin
          if (out_free) begin
            res_load   = 1'b1;
            res_status = srs_pkg::ST_DUPLICATE;
            state_next = S_IDLE;
          end
        end else begin
          flag_we    = 1'b1;
          flag_waddr = ack_idx;
          flag_wdata = 1'b1;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (window_base == next_seq) begin
          state_next = S_ADONE;
        end else begin
          state_next = S_WCHK;
        end
      end
      S_WCHK: begin
        if (flag_rdata) begin
          window_base_next = mod_inc(window_base);
          state_next       = S_WALK;
        end else begin
          state_next = S_ADONE;
        end
      end
      S_ADONE: begin
        if (out_free) begin
          res_load   = 1'b1;
          res_status = srs_pkg::ST_NEW_ACK;
          res_data[198:197] = (window_base == next_seq) ? srs_pkg::TMR_STOP
                                                        : srs_pkg::TMR_RESTART;
          state_next = S_IDLE;
        end
      end
      S_RS: begin
        if (out_free) begin
          res_load   = 1'b1;
          res_status = srs_pkg::ST_RESENT;
          res_data   = {1'b0, srs_pkg::TMR_RESTART,
                        pay[159:128], pay[127:64], pay[63:0],
                        32'(window_base) + srs_pkg::ACK_FIELD_NONE + 32'(psum),
                        4'(window_base), 1'b1};
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      window_base   <= '0;
      next_seq      <= '0;
      window_limit  <= srs_pkg::WINDOW_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      state       <= state_next;
      window_base <= window_base_next;
      next_seq    <= next_seq_next;
      if (cfg_wr && paddr[2] == srs_pkg::REG_WINDOW_LIMIT) begin
        window_limit <= pwdata[3:0];
      end
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (res_load) begin
        m_axis_tvalid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      kind    <= s_axis_tuser;
      pay     <= s_axis_tdata[159:0];
      ack_seq <= s_axis_tdata[191:160];
      ack_num <= s_axis_tdata[223:192];
      ack_chk <= s_axis_tdata[255:224];
    end else if (state == S_RD) begin
      pay <= pay_rdata;
    end
    if (state == S_SUM) begin
      for (int k = 0; k < srs_pkg::GROUPS; k++) begin
        grp[k] <= srs_pkg::group_sum(pay[32*k +: 32]);
      end
    end
    if (res_load) begin
      m_axis_tdata <= res_data;
      m_axis_tuser <= res_status;
    end
  end

endmodule
